// ----- design/dq_pkg.sv -----
// Shared types, constants and index helpers for the double-ended queue.
package dq_pkg;

    // Queue capacity and the widths that follow from it.
    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam cnt_t DEPTH_CNT = cnt_t'(DEPTH);
    localparam idx_t LAST_IDX = idx_t'(DEPTH - 1);

    // Request kinds carried on the input tuser.
    typedef enum logic [2:0] {
        KIND_DUMP       = 3'd0,
        KIND_PUSH_FRONT = 3'd1,
        KIND_PUSH_BACK  = 3'd2,
        KIND_POP_FRONT  = 3'd3,
        KIND_POP_BACK   = 3'd4
    } kind_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    // One result transaction.
    typedef struct packed {
        logic signed [DATA_W-1:0] value_res;
        status_t                  status;
        logic                     last;
    } res_t;

    // One cycle of memory traffic from the controller.
    typedef struct packed {
        logic              wr_en;
        idx_t              wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        idx_t              rd_addr;
    } mem_req_t;

    // Controller status seen by the top level.
    typedef struct packed {
        logic busy;
        cnt_t occupancy;
    } ctrl_stat_t;

    // Slot that lies off entries behind base, wrapped around the ring.
    function automatic idx_t idx_add(idx_t base, cnt_t off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH))
        begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return idx_t'(sum);
    endfunction

    // Next slot toward the back.
    function automatic idx_t idx_inc(idx_t idx);
        return (idx == LAST_IDX) ? '0 : idx_t'(idx + 1'b1);
    endfunction

    // Next slot toward the front.
    function automatic idx_t idx_dec(idx_t idx);
        return (idx == '0) ? LAST_IDX : idx_t'(idx - 1'b1);
    endfunction

endpackage

// ----- design/dq_mem.sv -----
// Entry store: one write port and one registered read port.
module dq_mem (
    input  logic                          clk,
    input  dq_pkg::mem_req_t              req,
    output logic [dq_pkg::DATA_W-1:0]     rd_data
);
    import dq_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Read port; the data holds while no new read is issued.
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/dq_ctrl.sv -----
// Request decoder, ring pointers and dump sequencer.
module dq_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    in_kind,
    input  logic signed [dq_pkg::DATA_W-1:0] in_value,
    input  logic                          out_ready,
    output logic                          res_valid,
    output dq_pkg::res_t                  res,
    output dq_pkg::mem_req_t              mem_req,
    input  logic [dq_pkg::DATA_W-1:0]     rd_data,
    output dq_pkg::ctrl_stat_t            stat
);
    import dq_pkg::*;

    state_t state_reg, state_next;
    idx_t   head_reg, head_next;
    cnt_t   occ_reg, occ_next;
    cnt_t   dump_off_reg, dump_off_next;
    cnt_t   off_inc;
    idx_t   front_slot;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            occ_reg      <= '0;
            dump_off_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            occ_reg      <= occ_next;
            dump_off_reg <= dump_off_next;
        end
    end

    assign off_inc    = cnt_t'(dump_off_reg + 1'b1);
    assign front_slot = idx_dec(head_reg);

    // Next state, memory traffic and result generation.
    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        occ_next      = occ_reg;
        dump_off_next = dump_off_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        res.value_res = '0;
        res.status    = ST_OK;
        res.last      = 1'b1;
        mem_req       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = out_ready;
                if (in_valid && out_ready)
                begin
                    unique case (in_kind)
                        KIND_DUMP:
                        begin
                            if (occ_reg == '0)
                            begin
                                res_valid  = 1'b1;
                                res.status = ST_EMPTY;
                            end
                            else
                            begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = head_reg;
                                dump_off_next   = '0;
                                state_next      = S_DUMP;
                            end
                        end
                        KIND_PUSH_FRONT:
                        begin
                            res_valid = 1'b1;
                            if (occ_reg == DEPTH_CNT)
                            begin
                                res.status = ST_FULL;
                            end
                            else
                            begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = front_slot;
                                mem_req.wr_data = in_value;
                                head_next       = front_slot;
                                occ_next        = cnt_t'(occ_reg + 1'b1);
                            end
                        end
                        KIND_PUSH_BACK:
                        begin
                            res_valid = 1'b1;
                            if (occ_reg == DEPTH_CNT)
                            begin
                                res.status = ST_FULL;
                            end
                            else
                            begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = idx_add(head_reg, occ_reg);
                                mem_req.wr_data = in_value;
                                occ_next        = cnt_t'(occ_reg + 1'b1);
                            end
                        end
                        KIND_POP_FRONT:
                        begin
                            res_valid = 1'b1;
                            if (occ_reg == '0)
                            begin
                                res.status = ST_EMPTY;
                            end
                            else
                            begin
                                head_next = idx_inc(head_reg);
                                occ_next  = cnt_t'(occ_reg - 1'b1);
                            end
                        end
                        KIND_POP_BACK:
                        begin
                            res_valid = 1'b1;
                            if (occ_reg == '0)
                            begin
                                res.status = ST_EMPTY;
                            end
                            else
                            begin
                                occ_next = cnt_t'(occ_reg - 1'b1);
                            end
                        end
                        default:
                        begin
                            // Unused kinds are taken and dropped.
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                // Read data for offset dump_off_reg waits until the output takes it.
                if (out_ready)
                begin
                    res_valid     = 1'b1;
                    res.value_res = rd_data;
                    res.last      = (off_inc == occ_reg);
                    if (off_inc == occ_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = idx_add(head_reg, off_inc);
                        dump_off_next   = off_inc;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign stat.busy      = (state_reg == S_DUMP);
    assign stat.occupancy = occ_reg;

endmodule

// ----- design/dq_out.sv -----
// Output register that holds one result transaction until the receiver takes it.
module dq_out (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          res_valid,
    input  dq_pkg::res_t  res,
    output logic          out_ready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [39:0]   m_tdata,
    output logic          m_tlast
);
    import dq_pkg::*;

    logic obuf_valid_reg;
    res_t obuf_reg;

    // A new result may load when the register is empty or draining.
    assign out_ready = !obuf_valid_reg || m_tready;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obuf_valid_reg <= 1'b0;
        end
        else if (res_valid && out_ready)
        begin
            obuf_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            obuf_valid_reg <= 1'b0;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (res_valid && out_ready)
        begin
            obuf_reg <= res;
        end
    end

    assign m_tvalid = obuf_valid_reg;
    assign m_tdata  = {6'b0, obuf_reg.value_res, obuf_reg.status};
    assign m_tlast  = obuf_reg.last;

endmodule

// ----- design/double_ended_queue.sv -----
// Top level of the bounded double-ended queue of signed 32-bit values.
//
// Input channel (s_*): tuser carries the request kind (dump, push front,
// push back, pop front, pop back) and tdata the value to push. Output
// channel (m_*): tdata carries status and value_res, tlast marks the final
// result of a request.
// Pushes write the entry memory in the cycle they are accepted; pushes and
// pops give one result transaction in the cycle after. With the receiver ready
// the block takes one such request per cycle.
// In a dump, the single read port of the entry memory delivers one stored
// value per cycle while the output can load, front to back, and no new
// request is taken until the last value has been handed to the output.
// Unused kind codes are accepted and produce no result.
// Reset empties the queue at once; the entry memory is not cleared and
// needs no clearing pass.
// When the receiver stalls, the result stays in the output register and the
// input channel holds off until that register can load again.
module double_ended_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // [31:0] value
    input  logic [2:0]   s_tuser,   // [2:0] kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,   // [1:0] status, [33:2] value_res, [39:34] zero
    output logic         m_tlast    // last
);
    import dq_pkg::*;

    logic              out_ready;
    logic              res_valid;
    res_t              res;
    mem_req_t          mem_req;
    logic [DATA_W-1:0] rd_data;
    ctrl_stat_t        stat;

    // Entry memory.
    dq_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // Control and pointers.
    dq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_value  (s_tdata),
        .out_ready (out_ready),
        .res_valid (res_valid),
        .res       (res),
        .mem_req   (mem_req),
        .rd_data   (rd_data),
        .stat      (stat)
    );

    // Output register.
    dq_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // The fill count never goes past the capacity.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.occupancy <= DEPTH_CNT)
        else $error("queue occupancy exceeds capacity");

    // No new request is taken while a dump is running.
    a_no_accept_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy |-> !s_tready)
        else $error("request accepted during a dump");

    // A stalled result blocks the input side.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("request accepted while output is stalled");

    // A pop from a non-empty queue removes exactly one value.
    a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && stat.occupancy != '0
         && (s_tuser == KIND_POP_FRONT || s_tuser == KIND_POP_BACK))
        |=> stat.occupancy == cnt_t'($past(stat.occupancy) - 1'b1))
        else $error("pop did not remove one value");

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the bounded double-ended queue.
module tb_top;
    import dq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;    // [31:0] value
    logic [2:0]   s_tuser = '0;    // [2:0] kind
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [39:0]  m_tdata;         // [1:0] status, [33:2] value_res, [39:34] zero
    logic         m_tlast;

    // Shared test state: idling switch, receiver hold-off request, error count.
    bit   idle_en = 1'b0;
    int   hold_cycles = 0;
    int   error_count = 0;
    int   cycle_count = 0;

    // Predicted contents of the queue and the results still to arrive.
    logic signed [DATA_W-1:0] model_slots [DEPTH];
    int   model_front = 0;
    int   model_count = 0;
    res_t expected_results [$];

    double_ended_queue DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // Cycle counter that ends a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Queue one result that the block has to produce.
    function automatic void expect_result(status_t status, logic signed [DATA_W-1:0] value,
                                          logic last);
        res_t r;
        r.status = status;
        r.value_res = value;
        r.last = last;
        expected_results.push_back(r);
    endfunction

    // Apply one accepted request to the predicted queue and record its results.
    function automatic void predict_request(logic [2:0] kind, logic [31:0] value);
        int i;
        case (kind)
            KIND_DUMP:
            begin
                if (model_count == 0)
                begin
                    expect_result(ST_EMPTY, '0, 1'b1);
                end
                else
                begin
                    for (i = 0; i < model_count; i++)
                    begin
                        expect_result(ST_OK, model_slots[(model_front + i) % DEPTH],
                                      (i == model_count - 1));
                    end
                end
            end
            KIND_PUSH_FRONT, KIND_PUSH_BACK:
            begin
                if (model_count >= DEPTH)
                begin
                    expect_result(ST_FULL, '0, 1'b1);
                end
                else
                begin
                    if (kind == KIND_PUSH_FRONT)
                    begin
                        model_front = (model_front + DEPTH - 1) % DEPTH;
                        model_slots[model_front] = value;
                    end
                    else
                    begin
                        model_slots[(model_front + model_count) % DEPTH] = value;
                    end
                    model_count++;
                    expect_result(ST_OK, '0, 1'b1);
                end
            end
            KIND_POP_FRONT, KIND_POP_BACK:
            begin
                if (model_count == 0)
                begin
                    expect_result(ST_EMPTY, '0, 1'b1);
                end
                else
                begin
                    if (kind == KIND_POP_FRONT)
                    begin
                        model_front = (model_front + 1) % DEPTH;
                    end
                    model_count--;
                    expect_result(ST_OK, '0, 1'b1);
                end
            end
            default:
            begin
                // Unused kind codes produce nothing.
            end
        endcase
    endfunction

    // Offer one request, wait for its transaction, then predict its results.
    task automatic send_request(logic [2:0] kind, logic [31:0] value);
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= value;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predict_request(kind, value);
    endtask

    // Value with extra weight on the signed extremes.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Request kind biased by phase: 0 fills the queue, 1 drains it, 2 mixes.
    function automatic logic [2:0] pick_kind(int phase);
        int r;
        int push_limit;
        r = $urandom_range(0, 99);
        push_limit = (phase == 0) ? 78 : (phase == 1) ? 38 : 57;
        if (r >= 97)
        begin
            return 3'($urandom_range(5, 7));
        end
        if (r < 12)
        begin
            return KIND_DUMP;
        end
        if (r < push_limit)
        begin
            return $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
        end
        return $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
    endfunction

    // Receiver: long hold-off on request, random stall bursts while idling is on.
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (idle_en && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 19) - 1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge clk)
    begin : check_result
        res_t want;
        logic [1:0] got_status;
        logic signed [DATA_W-1:0] got_value;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_status = m_tdata[1:0];
            got_value = m_tdata[33:2];
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result: expected none, actual status %0d value %0d last %0d",
                         $time, got_status, got_value, m_tlast);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got_status !== want.status)
                begin
                    error_count++;
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, got_status);
                end
                if (got_value !== want.value_res)
                begin
                    error_count++;
                    $display("%0t: value mismatch: expected %0d, actual %0d",
                             $time, want.value_res, got_value);
                end
                if (m_tlast !== want.last)
                begin
                    error_count++;
                    $display("%0t: last mismatch: expected %0d, actual %0d",
                             $time, want.last, m_tlast);
                end
            end
        end
    end

    // Empty-queue cases, signed extremes, single-value pops and unused kinds.
    task automatic test_directed();
        send_request(KIND_DUMP, 32'h0);
        send_request(KIND_POP_FRONT, 32'h0);
        send_request(KIND_POP_BACK, 32'hFFFF_FFFF);
        send_request(KIND_PUSH_FRONT, 32'h7FFF_FFFF);
        send_request(KIND_PUSH_BACK, 32'h8000_0000);
        send_request(KIND_PUSH_FRONT, 32'hFFFF_FFFF);
        send_request(KIND_PUSH_BACK, 32'h0000_0000);
        send_request(KIND_DUMP, 32'h0);
        send_request(3'd5, 32'hFFFF_FFFF);
        send_request(3'd6, 32'h0);
        send_request(3'd7, 32'hA5A5_5A5A);
        send_request(KIND_POP_FRONT, 32'h0);
        send_request(KIND_POP_BACK, 32'h0);
        send_request(KIND_DUMP, 32'h0);
        send_request(KIND_POP_FRONT, 32'h0);
        // Back pop of the only value leaves the queue empty.
        send_request(KIND_POP_BACK, 32'h0);
        send_request(KIND_DUMP, 32'h0);
        send_request(KIND_PUSH_BACK, 32'h5555_5555);
        // Front pop of the only value leaves the queue empty.
        send_request(KIND_POP_FRONT, 32'h0);
        send_request(KIND_DUMP, 32'h0);
        send_request(KIND_POP_BACK, 32'h0);
    endtask

    // Fill to capacity, check that both pushes are refused, then drain.
    task automatic test_full_queue();
        int i;
        for (i = 0; i < DEPTH; i++)
        begin
            send_request($urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, pick_value());
        end
        send_request(KIND_PUSH_FRONT, 32'h1234_5678);
        send_request(KIND_PUSH_BACK, 32'h8765_4321);
        send_request(KIND_DUMP, 32'h0);
        send_request(KIND_POP_FRONT, 32'h0);
        send_request(KIND_PUSH_BACK, pick_value());
        send_request(KIND_PUSH_BACK, pick_value());
        send_request(KIND_DUMP, 32'h0);
        for (i = 0; i < DEPTH; i++)
        begin
            send_request($urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK, 32'h0);
        end
        send_request(KIND_DUMP, 32'h0);
    endtask

    // Receiver holds off for a long stretch while requests keep coming.
    task automatic test_backpressure();
        int i;
        hold_cycles = 150;
        for (i = 0; i < 30; i++)
        begin
            send_request(pick_kind(i < 20 ? 0 : 2), pick_value());
        end
    endtask

    // Random traffic in fill, drain and mixed phases; unused kinds do not count.
    task automatic test_random_traffic(int count);
        int done;
        logic [2:0] kind;
        done = 0;
        while (done < count)
        begin
            kind = pick_kind((done / 24) % 3);
            send_request(kind, pick_value());
            if (kind <= KIND_POP_BACK)
            begin
                done++;
            end
        end
    endtask

    // Reset, run the tests in turn, then wait for every expected result.
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        idle_en = 1'b1;
        test_full_queue();
        test_backpressure();
        test_random_traffic(170);
        // Closing stretch at full rate.
        idle_en = 1'b0;
        test_random_traffic(60);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
